// ===== hdl/efsd_pkg.sv =====
`timescale 1ns / 1ps

package efsd_pkg;

    // Built server count and the widths that follow from it.
    localparam int MAX_WINDOWS = 16;
    localparam int IDX_W       = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);

    // Field widths.
    localparam int TIME_W  = 17;
    localparam int SVC_W   = 10;
    localparam int SEC_W   = 16;
    localparam int WIDE_W  = 32;
    localparam int COUNT_W = 16;
    localparam int NWIN_W  = 5;
    localparam int SRV_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    // Time constants.
    localparam logic [SEC_W-1:0]  SEC_PER_MIN = 16'd60;
    localparam logic [TIME_W-1:0] RESET_OPEN  = 17'd28800;
    localparam logic [TIME_W-1:0] RESET_CLOSE = 17'd61200;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_WINDOWS = 2'd0,
        CFG_OPEN_TIME   = 2'd1,
        CFG_CLOSE_TIME  = 2'd2
    } cfg_reg_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic update;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic late;
        logic scan_done;
        logic out_full;
    } dp_status_t;

endpackage

// ===== hdl/efsd_ctrl.sv =====
`timescale 1ns / 1ps

module efsd_ctrl
    import efsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.update    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                // A late arrival is taken and dropped without leaving idle.
                if (in_valid && !status.late)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_UPDATE:
            begin
                // Wait until the output register can take the result.
                if (!status.out_full)
                begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/efsd_dp.sv =====
`timescale 1ns / 1ps

module efsd_dp
    import efsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  logic [TIME_W-1:0]     arrival_sec,
    input  logic [SVC_W-1:0]      service_min,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SRV_W-1:0]      server_index,
    output logic [WIDE_W-1:0]     start_sec,
    output logic [WIDE_W-1:0]     wait_sec,
    output logic [WIDE_W-1:0]     total_wait_sec,
    output logic [COUNT_W-1:0]    served_count
);

    // Configuration registers.
    logic [NWIN_W-1:0] num_windows_reg;
    logic [TIME_W-1:0] close_time_reg;

    // Server free times and running totals.
    logic [WIDE_W-1:0]  free_reg [MAX_WINDOWS];
    logic [WIDE_W-1:0]  total_reg;
    logic [COUNT_W-1:0] served_reg;

    // Current customer and scan state.
    logic [TIME_W-1:0] arr_reg;
    logic [SEC_W-1:0]  svc_sec_reg;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [IDX_W-1:0]  best_reg;
    logic [WIDE_W-1:0] min_reg;

    // Output register.
    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [WIDE_W-1:0]  out_start_reg;
    logic [WIDE_W-1:0]  out_wait_reg;
    logic [WIDE_W-1:0]  out_total_reg;
    logic [COUNT_W-1:0] out_served_reg;

    logic [CNT_W-1:0]  n_act;
    logic [IDX_W-1:0]  scan_idx;
    logic [WIDE_W-1:0] cand;
    logic [WIDE_W-1:0] arr_wide;
    logic [WIDE_W-1:0] start_val;
    logic [WIDE_W-1:0] wait_val;
    logic [WIDE_W:0]   end_sum;
    logic [WIDE_W-1:0] end_val;
    logic [WIDE_W:0]   total_sum;
    logic [WIDE_W-1:0] total_next;
    logic [COUNT_W-1:0] served_next;

    // Active server count, clamped to the built range.
    always_comb
    begin
        if (num_windows_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (int'(num_windows_reg) > MAX_WINDOWS)
        begin
            n_act = CNT_W'(MAX_WINDOWS);
        end
        else
        begin
            n_act = CNT_W'(num_windows_reg);
        end
    end

    // Scan compare and result arithmetic.
    always_comb
    begin
        scan_idx  = scan_idx_reg[IDX_W-1:0];
        cand      = free_reg[scan_idx];
        arr_wide  = WIDE_W'(arr_reg);
        start_val = (arr_wide > min_reg) ? arr_wide : min_reg;
        wait_val  = start_val - arr_wide;
        end_sum   = {1'b0, start_val} + (WIDE_W+1)'(svc_sec_reg);
        end_val   = end_sum[WIDE_W] ? '1 : end_sum[WIDE_W-1:0];
        total_sum = {1'b0, total_reg} + {1'b0, wait_val};
        total_next = total_sum[WIDE_W] ? '1 : total_sum[WIDE_W-1:0];
        served_next = (served_reg == '1) ? served_reg : served_reg + COUNT_W'(1);
    end

    assign status.late      = (arrival_sec > close_time_reg);
    assign status.scan_done = (scan_idx_reg >= n_act);
    assign status.out_full  = out_valid_reg && !out_ready;

    // Configuration, free times, totals and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_windows_reg <= NWIN_W'(1);
            close_time_reg  <= RESET_CLOSE;
            for (int i = 0; i < MAX_WINDOWS; i++)
            begin
                free_reg[i] <= WIDE_W'(RESET_OPEN);
            end
            total_reg     <= '0;
            served_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_NUM_WINDOWS:
                    begin
                        num_windows_reg <= cfg_data[NWIN_W-1:0];
                    end
                    CFG_OPEN_TIME:
                    begin
                        // Every server becomes free at the new opening time.
                        for (int i = 0; i < MAX_WINDOWS; i++)
                        begin
                            free_reg[i] <= WIDE_W'(cfg_data);
                        end
                    end
                    CFG_CLOSE_TIME:
                    begin
                        close_time_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.update)
            begin
                free_reg[best_reg] <= end_val;
                total_reg          <= total_next;
                served_reg         <= served_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Customer capture, minimum scan and output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            arr_reg      <= arrival_sec;
            svc_sec_reg  <= SEC_W'(service_min) * SEC_PER_MIN;
            min_reg      <= free_reg[0];
            best_reg     <= '0;
            scan_idx_reg <= CNT_W'(1);
        end
        else if (cmd.scan_step)
        begin
            // Strict compare keeps the lowest index on a tie.
            if (cand < min_reg)
            begin
                min_reg  <= cand;
                best_reg <= scan_idx;
            end
            scan_idx_reg <= scan_idx_reg + CNT_W'(1);
        end
        if (cmd.update)
        begin
            out_idx_reg    <= best_reg;
            out_start_reg  <= start_val;
            out_wait_reg   <= wait_val;
            out_total_reg  <= total_next;
            out_served_reg <= served_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign server_index   = SRV_W'(out_idx_reg);
    assign start_sec      = out_start_reg;
    assign wait_sec       = out_wait_reg;
    assign total_wait_sec = out_total_reg;
    assign served_count   = out_served_reg;

    // The chosen server is always one of the active servers.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (CNT_W'(best_reg) < n_act))
        else $error("chosen server outside the active range");

    // An update always leaves a result in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> out_valid_reg)
        else $error("update did not load the output register");

    // An update never overwrites a result that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten while stalled");

    // The served count never goes down.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (served_reg >= $past(served_reg)))
        else $error("served count decreased");

    // The running wait total never goes down.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (total_reg >= $past(total_reg)))
        else $error("wait total decreased");

endmodule

// ===== hdl/earliest_free_server_dispatch.sv =====
`timescale 1ns / 1ps
// Earliest-free-server dispatch for a multi-server first-come first-served queue.
// Input channel (in_valid/in_ready): one customer per transfer, arrival second
// and service minutes. A customer arriving after close_time is taken and
// dropped with no result. Otherwise the customer goes to the active server that
// frees earliest, lowest index on a tie, and one result transfer follows on the
// output channel (out_valid/out_ready): server, start, wait, total wait, count.
// Configuration channel (cfg_valid/cfg_ready): index 0 num_windows, 1 open_time
// (reloads every server free time), 2 close_time; other indexes are ignored.
// Write configuration only while the block is idle.
// Sequence: N is num_windows clamped to 1..16. After the accept, the scan runs
// over a single free-time compare unit (one compare per cycle for the servers
// after the first, then a check that sees the scan is done), and the update
// step loads the result into the output register. A new customer is taken only
// once the previous one has passed the update step and the block is idle again.
// A stalled receiver holds the result in the output register; the next customer
// is still taken and scanned, then waits in the update step until it is free.
// Reset loads the register defaults (1 server, open 28800, close 61200), sets
// every free time to 28800 and clears the totals.

module earliest_free_server_dispatch
    import efsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TIME_W-1:0]     arrival_sec,
    input  logic [SVC_W-1:0]      service_min,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SRV_W-1:0]      server_index,
    output logic [WIDE_W-1:0]     start_sec,
    output logic [WIDE_W-1:0]     wait_sec,
    output logic [WIDE_W-1:0]     total_wait_sec,
    output logic [COUNT_W-1:0]    served_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    efsd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    efsd_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .arrival_sec    (arrival_sec),
        .service_min    (service_min),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .server_index   (server_index),
        .start_sec      (start_sec),
        .wait_sec       (wait_sec),
        .total_wait_sec (total_wait_sec),
        .served_count   (served_count)
    );

endmodule

// ===== tb/tb_earliest_free_server_dispatch.sv =====
`timescale 1ns / 1ps

module tb_earliest_free_server_dispatch;
    import efsd_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int MAX_ARRIVAL    = 86399;
    localparam int SETTLE_CYCLES  = 40;
    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_HOLD      = 300;
    localparam int RUSH_ITEMS     = 25;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 40;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 112;

    // Index that names no register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    // One dispatch result as the block reports it.
    typedef struct packed {
        logic [SRV_W-1:0]   server;
        logic [WIDE_W-1:0]  start;
        logic [WIDE_W-1:0]  waited;
        logic [WIDE_W-1:0]  total;
        logic [COUNT_W-1:0] count;
    } dispatch_t;

    // Tracks server free times and totals, and holds the dispatches still due.
    class dispatch_tracker;
        logic [NWIN_W-1:0]  num_windows;
        logic [TIME_W-1:0]  open_time;
        logic [TIME_W-1:0]  close_time;
        logic [WIDE_W-1:0]  free_time [MAX_WINDOWS];
        logic [WIDE_W-1:0]  wait_sum;
        logic [COUNT_W-1:0] served;
        dispatch_t          expected_dispatches [$];
        int                 err_count;

        function new();
            int i;
            num_windows = NWIN_W'(1);
            open_time   = RESET_OPEN;
            close_time  = RESET_CLOSE;
            for (i = 0; i < MAX_WINDOWS; i++)
                free_time[i] = WIDE_W'(RESET_OPEN);
            wait_sum  = '0;
            served    = '0;
            err_count = 0;
        endfunction

        task report(string what);
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("mismatch at %0t: %s", $realtime, what);
        endtask

        function int pending();
            return expected_dispatches.size();
        endfunction

        // Register write; a new open time frees every server at that second.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            int i;
            case (idx)
                CFG_NUM_WINDOWS: num_windows = data[NWIN_W-1:0];
                CFG_OPEN_TIME:
                begin
                    open_time = data[TIME_W-1:0];
                    for (i = 0; i < MAX_WINDOWS; i++)
                        free_time[i] = WIDE_W'(open_time);
                end
                CFG_CLOSE_TIME: close_time = data[TIME_W-1:0];
                default: ;
            endcase
        endfunction

        // Dispatch one accepted customer and queue the result it should give.
        function void admit_customer(logic [TIME_W-1:0] arrival, logic [SVC_W-1:0] service);
            int                active;
            int                best;
            int                i;
            logic [WIDE_W-1:0] free_at;
            logic [WIDE_W-1:0] start;
            logic [WIDE_W-1:0] waited;
            logic [WIDE_W:0]   finish_at;
            logic [WIDE_W:0]   sum;
            dispatch_t         d;

            // Customers after closing are dropped without a trace.
            if (arrival > close_time)
                return;

            if (num_windows == 0)
                active = 1;
            else if (num_windows > MAX_WINDOWS)
                active = MAX_WINDOWS;
            else
                active = int'(num_windows);

            // Earliest free server, lowest index on a tie.
            best    = 0;
            free_at = free_time[0];
            for (i = 1; i < active; i++)
            begin
                if (free_time[i] < free_at)
                begin
                    free_at = free_time[i];
                    best    = i;
                end
            end

            start  = (WIDE_W'(arrival) > free_at) ? WIDE_W'(arrival) : free_at;
            waited = start - WIDE_W'(arrival);

            finish_at = {1'b0, start}
                      + (WIDE_W+1)'(service) * (WIDE_W+1)'(SEC_PER_MIN);
            free_time[best] = finish_at[WIDE_W] ? '1 : finish_at[WIDE_W-1:0];

            sum      = {1'b0, wait_sum} + {1'b0, waited};
            wait_sum = sum[WIDE_W] ? '1 : sum[WIDE_W-1:0];
            if (served != '1)
                served++;

            d.server = SRV_W'(best);
            d.start  = start;
            d.waited = waited;
            d.total  = wait_sum;
            d.count  = served;
            expected_dispatches.push_back(d);
        endfunction

        // Compare one result transfer against the oldest dispatch due.
        task check_dispatch(logic [SRV_W-1:0] server, logic [WIDE_W-1:0] start,
                            logic [WIDE_W-1:0] waited, logic [WIDE_W-1:0] total,
                            logic [COUNT_W-1:0] count);
            dispatch_t d;
            if (expected_dispatches.size() == 0)
            begin
                report($sformatf("result with none due: server %0d start %0d", server, start));
                return;
            end
            d = expected_dispatches.pop_front();
            if (server !== d.server)
                report($sformatf("server_index %0d, want %0d", server, d.server));
            if (start !== d.start)
                report($sformatf("start_sec %0d, want %0d", start, d.start));
            if (waited !== d.waited)
                report($sformatf("wait_sec %0d, want %0d", waited, d.waited));
            if (total !== d.total)
                report($sformatf("total_wait_sec %0d, want %0d", total, d.total));
            if (count !== d.count)
                report($sformatf("served_count %0d, want %0d", count, d.count));
        endtask

        task flush_leftovers();
            while (expected_dispatches.size() != 0)
            begin
                report($sformatf("result never came: start %0d",
                                 expected_dispatches[0].start));
                void'(expected_dispatches.pop_front());
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [TIME_W-1:0]     arrival_sec;
    logic [SVC_W-1:0]      service_min;
    logic                  out_valid;
    logic                  out_ready;
    logic [SRV_W-1:0]      server_index;
    logic [WIDE_W-1:0]     start_sec;
    logic [WIDE_W-1:0]     wait_sec;
    logic [WIDE_W-1:0]     total_wait_sec;
    logic [COUNT_W-1:0]    served_count;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dispatch_tracker tracker;
    bit              long_hold_req;
    bit              no_idle;
    int              rush_left;

    earliest_free_server_dispatch i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .arrival_sec    (arrival_sec),
        .service_min    (service_min),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .server_index   (server_index),
        .start_sec      (start_sec),
        .wait_sec       (wait_sec),
        .total_wait_sec (total_wait_sec),
        .served_count   (served_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_service();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return $urandom_range(0, 30);
        if (r < 88)
            return $urandom_range(0, 200);
        return $urandom_range(0, 1023);
    endfunction

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Offer one customer and hold it until the input transfer.
    task automatic send_customer(input int arrival, input int service);
        in_valid    <= 1'b1;
        arrival_sec <= TIME_W'(arrival);
        service_min <= SVC_W'(service);
        do
            @(posedge clk);
        while (!in_ready);
        tracker.admit_customer(TIME_W'(arrival), SVC_W'(service));
    endtask

    task automatic wait_drained();
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // Registers change only with nothing in flight, dropped customers included.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int data);
        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_reg(idx, CFG_DATA_W'(data));
        cfg_valid <= 1'b0;
    endtask

    // Result receiver with random stalls and one long hold on request.
    initial
    begin
        int hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                hold = pick_gap();
                if (hold > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (hold) @(posedge clk);
                end
                out_ready <= 1'b1;
            end
        end
    end

    // Check every result transfer.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_dispatch(server_index, start_sec, wait_sec, total_wait_sec,
                                   served_count);
    end

    // Stop the run if no transfer of any kind happens for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_earliest_free_server_dispatch NOT OK");
        $finish;
    end

    // Stimulus.
    initial
    begin
        int phase;
        int k;
        int r;
        int arr;
        int a;
        int nwin;
        int open_t;
        int close_t;

        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        arrival_sec   = '0;
        service_min   = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_NUM_WINDOWS;
        cfg_data      = '0;
        long_hold_req = 1'b0;
        no_idle       = 1'b0;
        rush_left     = 0;
        tracker       = new();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one server, early arrival, arrival at and past closing.
        send_customer(0, 1023);
        send_customer(28800, 0);
        send_customer(61200, 5);
        send_customer(61201, 3);
        send_customer(MAX_ARRIVAL, 1023);
        send_customer(30000, 1);

        // All servers tied at zero: lowest index wins each tie.
        write_register(CFG_NUM_WINDOWS, MAX_WINDOWS);
        write_register(CFG_OPEN_TIME, 0);
        write_register(CFG_CLOSE_TIME, MAX_ARRIVAL);
        send_customer(0, 1023);
        send_customer(0, 1023);
        send_customer(0, 1023);
        send_customer(MAX_ARRIVAL, 1023);
        send_customer(100, 0);
        send_customer(50, 7);

        // Zero servers behave as one; latest open time.
        write_register(CFG_NUM_WINDOWS, 0);
        write_register(CFG_OPEN_TIME, MAX_ARRIVAL);
        send_customer(0, 10);
        send_customer(MAX_ARRIVAL, 0);

        // Too many servers clamp to the built count; closing at second zero.
        write_register(CFG_NUM_WINDOWS, 31);
        write_register(CFG_CLOSE_TIME, 0);
        send_customer(0, 7);
        send_customer(1, 5);

        // A write to the spare index must leave everything as it was.
        write_register(CFG_NUM_WINDOWS, 17);
        write_register(CFG_OPEN_TIME, 0);
        write_register(CFG_CLOSE_TIME, MAX_ARRIVAL);
        write_register(CFG_SPARE_INDEX, 5);
        send_customer(5, 2);
        send_customer(5, 2);
        send_customer(3, 1000);

        // Random phases, each with its own settings.
        for (phase = 0; phase < PHASES; phase++)
        begin
            no_idle = (phase % 4 == 1);
            case (phase)
                0:
                begin
                    nwin = 1; open_t = 0; close_t = MAX_ARRIVAL;
                end
                6:
                begin
                    nwin = 0; open_t = $urandom_range(0, 40000); close_t = MAX_ARRIVAL;
                end
                9:
                begin
                    nwin = 31; open_t = 28800; close_t = $urandom_range(40000, MAX_ARRIVAL);
                end
                11:
                begin
                    nwin = MAX_WINDOWS; open_t = MAX_ARRIVAL; close_t = MAX_ARRIVAL;
                end
                default:
                begin
                    nwin   = $urandom_range(1, MAX_WINDOWS);
                    open_t = $urandom_range(0, 50000);
                    if ($urandom_range(0, 99) < 80)
                        close_t = $urandom_range(open_t, MAX_ARRIVAL);
                    else
                        close_t = $urandom_range(0, MAX_ARRIVAL);
                end
            endcase
            write_register(CFG_NUM_WINDOWS, nwin);
            write_register(CFG_CLOSE_TIME, close_t);
            write_register(CFG_OPEN_TIME, open_t);
            @(posedge clk);

            arr = (open_t > 1000) ? open_t - 1000 : 0;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // Long receiver hold while the sender keeps offering.
                if (phase == 2 && k == 30)
                begin
                    long_hold_req = 1'b1;
                    rush_left     = RUSH_ITEMS;
                end
                // Sender waits for every outstanding result.
                if (phase == 5 && k == 50)
                begin
                    in_valid <= 1'b0;
                    wait_drained();
                    @(posedge clk);
                end

                r = $urandom_range(0, 99);
                if (r < 6)
                    a = $urandom_range(0, arr);
                else if (r < 11)
                    a = (close_t + 5000 > MAX_ARRIVAL) ?
                        MAX_ARRIVAL : $urandom_range(close_t + 1, close_t + 5000);
                else if (r < 14)
                    a = $urandom_range(0, MAX_ARRIVAL);
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        arr = arr;
                    else if (r < 90)
                        arr = arr + $urandom_range(0, 300);
                    else
                        arr = arr + $urandom_range(300, 3000);
                    if (arr > MAX_ARRIVAL)
                        arr = MAX_ARRIVAL;
                    a = arr;
                end

                if (rush_left > 0)
                    rush_left--;
                else
                    idle_sender(pick_gap());
                send_customer(a, pick_service());
            end
        end

        in_valid <= 1'b0;
        no_idle = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        tracker.flush_leftovers();
        if (tracker.err_count == 0)
            $display("tb_earliest_free_server_dispatch OK");
        else
            $display("tb_earliest_free_server_dispatch NOT OK");
        $finish;
    end

endmodule
